// ===== rtl/dsv_pkg.sv =====
// shared types, constants and sine table for the decaying sine voice
package dsv_pkg;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_WAIT = 2'd1;
	localparam logic [1:0] OP_NOTE = 2'd2;

	localparam logic [7:0]  RATE_RESET  = 8'd172;
	localparam logic [15:0] NOTE_AMP    = 16'd29440;
	localparam logic [15:0] DECAY_NUM   = 16'd256;
	localparam logic [15:0] WAIT_MAX    = 16'hFFFF;
	localparam logic signed [8:0] ROM_CENTER = 9'sd127;
	localparam int          DIV_STEPS   = 16;
	localparam int          CNT_W       = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_COMMIT,
		ST_UPDATE,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic dec_wait;
		logic load_wait;
		logic div_start;
		logic div_step;
		logic div_commit;
		logic update;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic       wait_zero;
		logic [1:0] op;
		logic       out_free;
	} status_t;

	localparam logic [7:0] SINE_ROM [256] = '{
		8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
		8'd152, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
		8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd191, 8'd193, 8'd196,
		8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd216,
		8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
		8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd245,
		8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252,
		8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254,
		8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247,
		8'd246, 8'd245, 8'd243, 8'd242, 8'd240, 8'd239, 8'd237, 8'd236,
		8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
		8'd218, 8'd216, 8'd213, 8'd211, 8'd209, 8'd206, 8'd204, 8'd201,
		8'd199, 8'd196, 8'd193, 8'd191, 8'd188, 8'd185, 8'd182, 8'd179,
		8'd176, 8'd174, 8'd171, 8'd168, 8'd165, 8'd162, 8'd159, 8'd156,
		8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
		8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
		8'd103, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
		8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,  8'd59,
		8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,  8'd39,
		8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
		8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
		8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
		8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
		8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
		8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
		8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
		8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
		8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,
		8'd79,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
		8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
	};

endpackage

// ===== rtl/dsv_in_if.sv =====
// input channel: event word per sample
interface dsv_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] event_arg;

	modport source (output valid, output op, output event_arg, input ready);
	modport sink (input valid, input op, input event_arg, output ready);
endinterface

// ===== rtl/dsv_out_if.sv =====
// output channel: sample word and event request
interface dsv_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] sample;
	logic              event_request;

	modport source (output valid, output sample, output event_request, input ready);
	modport sink (input valid, input sample, input event_request, output ready);
endinterface

// ===== rtl/dsv_ctrl.sv =====
// sequencer: per-sample control and divider step counter
module dsv_ctrl import dsv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  status_t status,
	output cmd_t    cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!status.wait_zero) begin
					cmd.dec_wait = 1'b1;
					state_d      = ST_UPDATE;
				end else if (status.op == OP_WAIT) begin
					cmd.load_wait = 1'b1;
					state_d       = ST_UPDATE;
				end else if (status.op == OP_NOTE) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.div_commit = 1'b1;
				state_d        = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_OUTPUT;
			end
			ST_OUTPUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/dsv_datapath.sv =====
// voice state, iterative divider, sine lookup and output register
module dsv_datapath import dsv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic              in_valid,
	input  logic [1:0]        in_op,
	input  logic [15:0]       in_arg,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              out_ready,
	output logic              out_valid,
	output logic signed [7:0] out_sample,
	output logic              out_event_request
);

	logic [7:0]  rate_q;
	logic [15:0] amplitude_q;
	logic [15:0] decay_step_q;
	logic [15:0] phase_q;
	logic [15:0] phase_step_q;
	logic [15:0] wait_count_q;
	logic        out_valid_q;

	logic [1:0]  op_q;
	logic [15:0] arg_q;
	logic [7:0]  dvs_q;
	logic        neg_q;
	logic [7:0]  ra_q, rb_q;
	logic [15:0] na_q, nb_q;
	logic signed [7:0] sample_q;
	logic        event_req_q;

	logic [15:0] num;
	logic [15:0] mag;
	logic [21:0] wait_prod;
	logic [15:0] wait_sat;
	logic [8:0]  ta, tb;
	logic        gea, geb;
	logic [15:0] amp_next;
	logic signed [8:0]  rom_c;
	logic signed [17:0] prod;
	logic signed [17:0] adj;
	logic signed [17:0] quo;

	assign num       = {arg_q[11:0], 4'b0000};
	assign mag       = num[15] ? (~num + 16'd1) : num;
	assign wait_prod = {8'b0, arg_q[15:2]} * {14'b0, rate_q};
	assign wait_sat  = (|wait_prod[21:16]) ? WAIT_MAX : wait_prod[15:0];

	// one restoring step per cycle on both lanes
	assign ta  = {ra_q, na_q[15]};
	assign tb  = {rb_q, nb_q[15]};
	assign gea = ta >= {1'b0, dvs_q};
	assign geb = tb >= {1'b0, dvs_q};

	assign amp_next = (amplitude_q < decay_step_q) ? 16'd0 : (amplitude_q - decay_step_q);

	assign rom_c = $signed({1'b0, SINE_ROM[phase_q[13:6]]}) - ROM_CENTER;
	assign prod  = 18'($signed({1'b0, amplitude_q[15:8]})) * 18'(rom_c);
	// round toward zero before the shift
	assign adj   = prod + (prod[17] ? 18'sd127 : 18'sd0);
	assign quo   = adj >>> 7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q       <= RATE_RESET;
			amplitude_q  <= '0;
			decay_step_q <= '0;
			phase_q      <= '0;
			phase_step_q <= '0;
			wait_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			if (cmd.dec_wait) begin
				wait_count_q <= wait_count_q - 16'd1;
			end else if (cmd.load_wait) begin
				wait_count_q <= wait_sat;
			end
			if (cmd.div_commit) begin
				phase_step_q <= neg_q ? (~na_q + 16'd1) : na_q;
				decay_step_q <= nb_q;
				amplitude_q  <= NOTE_AMP;
			end else if (cmd.update) begin
				amplitude_q <= amp_next;
				phase_q     <= phase_q + phase_step_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_ready && in_valid) begin
			op_q  <= in_op;
			arg_q <= in_arg;
		end
		if (cmd.div_start) begin
			dvs_q <= (rate_q == 8'd0) ? 8'd1 : rate_q;
			neg_q <= num[15];
			ra_q  <= '0;
			rb_q  <= '0;
			na_q  <= mag;
			nb_q  <= DECAY_NUM;
		end else if (cmd.div_step) begin
			ra_q <= gea ? 8'(ta - {1'b0, dvs_q}) : ta[7:0];
			rb_q <= geb ? 8'(tb - {1'b0, dvs_q}) : tb[7:0];
			na_q <= {na_q[14:0], gea};
			nb_q <= {nb_q[14:0], geb};
		end
		if (cmd.out_load) begin
			sample_q    <= quo[7:0];
			event_req_q <= (wait_count_q == 16'd0);
		end
	end

	assign status.wait_zero = (wait_count_q == 16'd0);
	assign status.op        = op_q;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign out_sample        = sample_q;
	assign out_event_request = event_req_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded word not presented");

	a_div_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.div_commit) |-> (wait_count_q == 16'd0))
		else $error("note division while wait pending");

	a_amp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		amplitude_q <= NOTE_AMP)
		else $error("amplitude above note level");

endmodule

// ===== rtl/decaying_sine_voice_sequenced.sv =====
// Decaying sine voice: one input word per audio sample, one output word back.
// A plain sample or a wait countdown passes from acceptance to the output
// register through accept, event decode, amplitude/phase update and output load;
// a note event adds the 16-step restoring divider that forms the phase step and
// decay step, plus a commit state, before the update. The next word is accepted
// once the previous one sits in the output register, and a result not yet taken
// holds the sequencer in its output state. The user must write the rate divisor
// through cfg_we/cfg_wdata only while the block is idle; it is not enforced.
module decaying_sine_voice_sequenced import dsv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	dsv_in_if.sink    items,
	dsv_out_if.source results
);

	cmd_t    cmd;
	status_t status;

	dsv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.status   (status),
		.cmd      (cmd)
	);

	dsv_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.in_valid          (items.valid),
		.in_op             (items.op),
		.in_arg            (items.event_arg),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.out_ready         (results.ready),
		.out_valid         (results.valid),
		.out_sample        (results.sample),
		.out_event_request (results.event_request)
	);

	assign items.ready = cmd.in_ready;

endmodule
